@@ sv/arpd_pkg.sv @@
// Shared constants and types for the addressed RGB packet PWM driver.
package arpd_pkg;

    // Default level width and field widths
    localparam int LEVEL_BITS_DEF = 8;
    localparam int BYTE_BITS      = 8;
    localparam int PHASE_BITS     = 4;
    localparam int CFG_IDX_BITS   = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_ADDR  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_ADDR = 1'd1;

    // Reset values
    localparam logic [BYTE_BITS-1:0] FIRST_ADDR_RST  = 8'h00;
    localparam logic [BYTE_BITS-1:0] SECOND_ADDR_RST = 8'hcc;
    localparam int                   RED_LEVEL_RST   = 12;

    // Input word opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // Frame parser phases
    localparam logic [PHASE_BITS-1:0] PH_ADDR1 = 4'd0;
    localparam logic [PHASE_BITS-1:0] PH_ADDR2 = 4'd1;
    localparam logic [PHASE_BITS-1:0] PH_RED   = 4'd2;
    localparam logic [PHASE_BITS-1:0] PH_GREEN = 4'd3;
    localparam logic [PHASE_BITS-1:0] PH_BLUE  = 4'd4;
    localparam logic [PHASE_BITS-1:0] PH_SKIP4 = 4'd5;
    localparam logic [PHASE_BITS-1:0] PH_SKIP3 = 4'd6;
    localparam logic [PHASE_BITS-1:0] PH_SKIP2 = 4'd7;
    localparam logic [PHASE_BITS-1:0] PH_SKIP1 = 4'd8;

    // Per-word control handed to the parser and the counter
    typedef struct packed {
        logic                 tick_en;
        logic                 byte_en;
        logic [BYTE_BITS-1:0] rx_byte;
    } t_step;

endpackage

@@ sv/arpd_in_if.sv @@
// Input channel: tick or received byte, with valid/ready handshake.
interface arpd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

@@ sv/arpd_out_if.sv @@
// Result channel: LED drives and frame completion flag, with valid/ready handshake.
interface arpd_out_if;
    logic valid;
    logic ready;
    logic led_red;
    logic led_green;
    logic led_blue;
    logic frame_done;

    modport source (output valid, output led_red, output led_green, output led_blue,
                    output frame_done, input ready);
    modport sink   (input valid, input led_red, input led_green, input led_blue,
                    input frame_done, output ready);
endinterface

@@ sv/arpd_parser.sv @@
// Five-byte frame parser: address match, skip counting and level registers.
module arpd_parser #(
    parameter int LEVEL_BITS = arpd_pkg::LEVEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arpd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [arpd_pkg::BYTE_BITS-1:0]      i_cfg_data,
    input  arpd_pkg::t_step                     i_step,
    output logic [LEVEL_BITS-1:0]               o_red,
    output logic [LEVEL_BITS-1:0]               o_green,
    output logic [LEVEL_BITS-1:0]               o_blue,
    output logic                                o_done
);

    logic [arpd_pkg::BYTE_BITS-1:0]  r_first_addr;
    logic [arpd_pkg::BYTE_BITS-1:0]  r_second_addr;
    logic [arpd_pkg::PHASE_BITS-1:0] r_phase, n_phase;
    logic [LEVEL_BITS-1:0]           r_red, n_red;
    logic [LEVEL_BITS-1:0]           r_green, n_green;
    logic [LEVEL_BITS-1:0]           r_blue, n_blue;
    logic [LEVEL_BITS+arpd_pkg::BYTE_BITS-1:0] byte_ext;
    logic [LEVEL_BITS-1:0]           byte_lvl;
    logic                            done;

    // Byte as a level: low LEVEL_BITS bits, zero-extended when wider
    assign byte_ext = {{LEVEL_BITS{1'b0}}, i_step.rx_byte};
    assign byte_lvl = byte_ext[LEVEL_BITS-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_addr  <= arpd_pkg::FIRST_ADDR_RST;
            r_second_addr <= arpd_pkg::SECOND_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arpd_pkg::REG_FIRST_ADDR:  r_first_addr  <= i_cfg_data;
                arpd_pkg::REG_SECOND_ADDR: r_second_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame phase and level updates for one byte
    always_comb begin
        n_phase = r_phase;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        done    = 1'b0;
        if (i_step.byte_en) begin
            case (r_phase)
                arpd_pkg::PH_ADDR1: begin
                    n_phase = (i_step.rx_byte == r_first_addr) ?
                              arpd_pkg::PH_ADDR2 : arpd_pkg::PH_SKIP4;
                end
                arpd_pkg::PH_ADDR2: begin
                    n_phase = (i_step.rx_byte == r_second_addr) ?
                              arpd_pkg::PH_RED : arpd_pkg::PH_SKIP3;
                end
                arpd_pkg::PH_RED: begin
                    n_red   = byte_lvl;
                    n_phase = arpd_pkg::PH_GREEN;
                end
                arpd_pkg::PH_GREEN: begin
                    n_green = byte_lvl;
                    n_phase = arpd_pkg::PH_BLUE;
                end
                arpd_pkg::PH_BLUE: begin
                    n_blue  = byte_lvl;
                    n_phase = arpd_pkg::PH_ADDR1;
                    done    = 1'b1;
                end
                arpd_pkg::PH_SKIP4, arpd_pkg::PH_SKIP3, arpd_pkg::PH_SKIP2: begin
                    n_phase = r_phase + 4'd1;
                end
                default: n_phase = arpd_pkg::PH_ADDR1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= arpd_pkg::PH_ADDR1;
            r_red   <= LEVEL_BITS'(arpd_pkg::RED_LEVEL_RST);
            r_green <= '0;
            r_blue  <= '0;
        end else begin
            r_phase <= n_phase;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    // Levels as they stand after this byte
    assign o_red   = n_red;
    assign o_green = n_green;
    assign o_blue  = n_blue;
    assign o_done  = done;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= arpd_pkg::PH_SKIP1)
        else $error("parser phase left the frame sequence");
    a_done_only_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_phase == arpd_pkg::PH_ADDR1) && (r_blue == $past(byte_lvl)))
        else $error("frame completion without blue level store");
    a_skip_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase >= arpd_pkg::PH_SKIP4) |=> $stable(r_red) && $stable(r_green) &&
                                            $stable(r_blue))
        else $error("level changed while skipping a frame");
`endif

endmodule

@@ sv/arpd_pwm.sv @@
// Free-running PWM counter and level compares for the three LEDs.
module arpd_pwm #(
    parameter int LEVEL_BITS = arpd_pkg::LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  arpd_pkg::t_step       i_step,
    input  logic [LEVEL_BITS-1:0] i_red,
    input  logic [LEVEL_BITS-1:0] i_green,
    input  logic [LEVEL_BITS-1:0] i_blue,
    output logic [2:0]            o_leds
);

    logic [LEVEL_BITS-1:0] r_count;

    // Counter advances on ticks only, wrapping at 2^LEVEL_BITS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step.tick_en) begin
            r_count <= r_count + LEVEL_BITS'(1);
        end
    end

    // LEDs from the count before this word
    assign o_leds = {r_count < i_blue, r_count < i_green, r_count < i_red};

endmodule

@@ sv/addressed_rgb_packet_pwm_driver.sv @@
// Top level: addressed RGB packet parser with three-channel PWM LED drive.
//
//  channel   dir   handshake         payload
//  i_rx      in    valid / ready     opcode, rx_byte
//  o_res     out   valid / ready     led_red, led_green, led_blue, frame_done
//  i_cfg_*   in    write enable      index (0 first address, 1 second address), data
//
//  One word per cycle while the result register is empty or being taken; each result
//  appears in the cycle after its word is accepted. The parser, levels and counter
//  update at the accept edge; the result register holds the LEDs and frame flag until
//  taken. A new word is accepted whenever the result register is empty or being taken.
//  Synchronous active-low reset clears parser phase, green and blue levels, counter and valid, and sets red to 12.
module addressed_rgb_packet_pwm_driver #(
    parameter int LEVEL_BITS = arpd_pkg::LEVEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    arpd_in_if.sink                           i_rx,
    arpd_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [arpd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [arpd_pkg::BYTE_BITS-1:0]    i_cfg_data
);

    arpd_pkg::t_step       step;
    logic                  accept;
    logic [LEVEL_BITS-1:0] lvl_red, lvl_green, lvl_blue;
    logic                  done;
    logic [2:0]            leds;
    logic                  r_valid;
    logic [2:0]            r_leds;
    logic                  r_done;

    // Handshake: room when the result register is empty or draining
    assign i_rx.ready = !r_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    // Word decode
    assign step.tick_en = accept && (i_rx.opcode == arpd_pkg::OP_TICK);
    assign step.byte_en = accept && (i_rx.opcode == arpd_pkg::OP_BYTE);
    assign step.rx_byte = i_rx.rx_byte;

    arpd_parser #(.LEVEL_BITS(LEVEL_BITS)) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .o_red       (lvl_red),
        .o_green     (lvl_green),
        .o_blue      (lvl_blue),
        .o_done      (done)
    );

    arpd_pwm #(.LEVEL_BITS(LEVEL_BITS)) u_pwm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_red   (lvl_red),
        .i_green (lvl_green),
        .i_blue  (lvl_blue),
        .o_leds  (leds)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_leds <= leds;
            r_done <= done;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.led_red    = r_leds[0];
    assign o_res.led_green  = r_leds[1];
    assign o_res.led_blue   = r_leds[2];
    assign o_res.frame_done = r_done;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res.valid)
        else $error("accepted word produced no result");
    a_tick_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx.opcode == arpd_pkg::OP_TICK) |=> !o_res.frame_done)
        else $error("frame completion flagged on a tick");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> i_rx.ready)
        else $error("input stalled with empty result register");
`endif

endmodule
